[sv/tgad_pkg.sv]
// shared types, header layout and result codes for the targa stream decoder
package tgad_pkg;

  // header byte positions that complete a field
  localparam logic [4:0] HDR_ID_LEN       = 5'd0;
  localparam logic [4:0] HDR_CMAP_TYPE    = 5'd1;
  localparam logic [4:0] HDR_IMG_TYPE     = 5'd2;
  localparam logic [4:0] HDR_CMAP_FIRST   = 5'd4;
  localparam logic [4:0] HDR_CMAP_LEN     = 5'd6;
  localparam logic [4:0] HDR_CMAP_ENTRY   = 5'd7;
  localparam logic [4:0] HDR_X_ORIGIN     = 5'd9;
  localparam logic [4:0] HDR_Y_ORIGIN     = 5'd11;
  localparam logic [4:0] HDR_WIDTH        = 5'd13;
  localparam logic [4:0] HDR_HEIGHT       = 5'd15;
  localparam logic [4:0] HDR_DEPTH        = 5'd16;
  localparam logic [4:0] HDR_DESCRIPTOR   = 5'd17;

  localparam logic [7:0] TRUECOLOR_TYPE   = 8'd2;
  localparam logic [7:0] REQUIRED_DEPTH   = 8'd32;
  localparam logic [3:0] REQUIRED_ALPHA   = 4'd8;

  localparam int unsigned BYTES_PER_PIXEL = 4;
  localparam logic [1:0]  LAST_PIXEL_BYTE = 2'(BYTES_PER_PIXEL - 1);

  // descriptor bits that pick the orientation
  localparam int unsigned DESC_RIGHT_TO_LEFT = 4;
  localparam int unsigned DESC_TOP_TO_BOTTOM = 5;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef enum logic [2:0] {
    ERR_CMAP   = 3'd0,
    ERR_TYPE   = 3'd1,
    ERR_XORG   = 3'd2,
    ERR_YORG   = 3'd3,
    ERR_WIDTH  = 3'd4,
    ERR_HEIGHT = 3'd5,
    ERR_DEPTH  = 3'd6,
    ERR_ALPHA  = 3'd7
  } tgad_err_e;

  // work item handed from the parser to the address unit
  typedef struct packed {
    logic        kind;
    logic [31:0] pixel_word;
    logic [15:0] dest_row;
    logic [15:0] dest_col;
    logic [15:0] width;
    logic [2:0]  error_code;
    logic        last_pixel;
  } tgad_item_t;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

endpackage

[sv/tgad_if.sv]
// byte input and result output channel interfaces
interface tgad_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface tgad_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] pixel_word;
  logic [31:0] dest_index;
  logic [2:0]  error_code;
  logic        last_pixel;

  modport source (output valid, output kind, output pixel_word, output dest_index,
                  output error_code, output last_pixel, input ready);
  modport sink   (input valid, input kind, input pixel_word, input dest_index,
                  input error_code, input last_pixel, output ready);
endinterface

[sv/tgad_front.sv]
// header parser, id skip and pixel assembler that issues work items
module tgad_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         data_byte_i,
  input  logic               start_of_file_i,
  output logic               push_o,
  output tgad_pkg::tgad_item_t push_item_o
);
  import tgad_pkg::*;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_ID     = 3'd2;
  localparam logic [2:0] PH_PIXEL  = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [4:0]  hdr_pos_q, hdr_pos_d;
  logic [7:0]  low_hold_q, low_hold_d;
  logic [7:0]  id_rem_q, id_rem_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [7:0]  desc_q, desc_d;
  logic [23:0] pix_bytes_q, pix_bytes_d;
  logic [1:0]  byte_idx_q, byte_idx_d;
  logic [15:0] src_col_q, src_col_d;
  logic [15:0] src_row_q, src_row_d;

  logic [2:0]  cur_phase;
  logic [4:0]  cur_pos;
  logic [15:0] hdr_word;
  logic        last_col, last_row;
  logic        err_hit;
  tgad_err_e   err_code;

  always_comb begin
    cur_phase   = start_of_file_i ? PH_HEADER : phase_q;
    cur_pos     = start_of_file_i ? 5'd0 : hdr_pos_q;
    hdr_word    = {data_byte_i, low_hold_q};
    last_col    = ({1'b0, src_col_q} + 17'd1) >= {1'b0, width_q};
    last_row    = ({1'b0, src_row_q} + 17'd1) >= {1'b0, height_q};

    phase_d     = phase_q;
    hdr_pos_d   = hdr_pos_q;
    low_hold_d  = low_hold_q;
    id_rem_d    = id_rem_q;
    width_d     = width_q;
    height_d    = height_q;
    desc_d      = desc_q;
    pix_bytes_d = pix_bytes_q;
    byte_idx_d  = byte_idx_q;
    src_col_d   = src_col_q;
    src_row_d   = src_row_q;
    err_hit     = 1'b0;
    err_code    = ERR_CMAP;

    push_o      = 1'b0;
    push_item_o = '0;

    if (accept_i) begin
      phase_d = cur_phase;
      case (cur_phase)
        PH_HEADER: begin
          hdr_pos_d  = cur_pos + 5'd1;
          low_hold_d = data_byte_i;
          case (cur_pos)
            HDR_ID_LEN: id_rem_d = data_byte_i;
            HDR_CMAP_TYPE: begin
              err_hit  = data_byte_i != 8'd0;
              err_code = ERR_CMAP;
            end
            HDR_IMG_TYPE: begin
              err_hit  = data_byte_i != TRUECOLOR_TYPE;
              err_code = ERR_TYPE;
            end
            HDR_CMAP_FIRST, HDR_CMAP_LEN: begin
              err_hit  = hdr_word != 16'd0;
              err_code = ERR_CMAP;
            end
            HDR_CMAP_ENTRY: begin
              err_hit  = data_byte_i != 8'd0;
              err_code = ERR_CMAP;
            end
            HDR_X_ORIGIN: begin
              err_hit  = hdr_word != 16'd0;
              err_code = ERR_XORG;
            end
            HDR_Y_ORIGIN: begin
              err_hit  = hdr_word != 16'd0;
              err_code = ERR_YORG;
            end
            HDR_WIDTH: begin
              width_d  = hdr_word;
              err_hit  = hdr_word == 16'd0;
              err_code = ERR_WIDTH;
            end
            HDR_HEIGHT: begin
              height_d = hdr_word;
              err_hit  = hdr_word == 16'd0;
              err_code = ERR_HEIGHT;
            end
            HDR_DEPTH: begin
              err_hit  = data_byte_i != REQUIRED_DEPTH;
              err_code = ERR_DEPTH;
            end
            HDR_DESCRIPTOR: begin
              desc_d   = data_byte_i;
              err_hit  = data_byte_i[3:0] != REQUIRED_ALPHA;
              err_code = ERR_ALPHA;
              if (!err_hit) begin
                phase_d     = (id_rem_q != 8'd0) ? PH_ID : PH_PIXEL;
                byte_idx_d  = 2'd0;
                pix_bytes_d = '0;
                src_col_d   = '0;
                src_row_d   = '0;
              end
            end
            default: ;
          endcase
          if (err_hit) begin
            phase_d                = PH_DONE;
            push_o                 = 1'b1;
            push_item_o.kind       = KIND_ERROR;
            push_item_o.error_code = err_code;
          end
        end
        PH_ID: begin
          id_rem_d = id_rem_q - 8'd1;
          if (id_rem_q == 8'd1) begin
            phase_d     = PH_PIXEL;
            byte_idx_d  = 2'd0;
            pix_bytes_d = '0;
            src_col_d   = '0;
            src_row_d   = '0;
          end
        end
        PH_PIXEL: begin
          if (byte_idx_q != LAST_PIXEL_BYTE) begin
            case (byte_idx_q)
              2'd0:    pix_bytes_d[7:0]   = data_byte_i;
              2'd1:    pix_bytes_d[15:8]  = data_byte_i;
              default: pix_bytes_d[23:16] = data_byte_i;
            endcase
            byte_idx_d = byte_idx_q + 2'd1;
          end else begin
            push_o                 = 1'b1;
            push_item_o.kind       = KIND_PIXEL;
            push_item_o.pixel_word = {data_byte_i, pix_bytes_q};
            push_item_o.dest_row   = desc_q[DESC_TOP_TO_BOTTOM] ? src_row_q
                                   : height_q - 16'd1 - src_row_q;
            push_item_o.dest_col   = desc_q[DESC_RIGHT_TO_LEFT]
                                   ? width_q - 16'd1 - src_col_q : src_col_q;
            push_item_o.width      = width_q;
            push_item_o.last_pixel = last_col && last_row;
            byte_idx_d  = 2'd0;
            pix_bytes_d = '0;
            if (last_col && last_row) begin
              phase_d = PH_DONE;
            end else if (last_col) begin
              src_col_d = '0;
              src_row_d = src_row_q + 16'd1;
            end else begin
              src_col_d = src_col_q + 16'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      hdr_pos_q   <= '0;
      low_hold_q  <= '0;
      id_rem_q    <= '0;
      width_q     <= '0;
      height_q    <= '0;
      desc_q      <= '0;
      pix_bytes_q <= '0;
      byte_idx_q  <= '0;
      src_col_q   <= '0;
      src_row_q   <= '0;
    end else begin
      phase_q     <= phase_d;
      hdr_pos_q   <= hdr_pos_d;
      low_hold_q  <= low_hold_d;
      id_rem_q    <= id_rem_d;
      width_q     <= width_d;
      height_q    <= height_d;
      desc_q      <= desc_d;
      pix_bytes_q <= pix_bytes_d;
      byte_idx_q  <= byte_idx_d;
      src_col_q   <= src_col_d;
      src_row_q   <= src_row_d;
    end
  end

endmodule

[sv/tgad_queue.sv]
// short work item queue between the parser and the address unit
module tgad_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tgad_pkg::tgad_item_t push_item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output tgad_pkg::tgad_item_t item_o
);
  import tgad_pkg::*;

  tgad_item_t             slots_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] count_q;
  logic                   do_push, do_pop;

  assign full_o  = count_q == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign item_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [QUEUE_PTR_W-1:0] next_ptr(input logic [QUEUE_PTR_W-1:0] p);
    return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QUEUE_CNT_W'(1);
      end
    end
  end

endmodule

[sv/tgad_back.sv]
// address unit: row times width product, column add and output register
module tgad_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  tgad_pkg::tgad_item_t item_i,
  output logic                 item_pop_o,
  tgad_out_if.source           out_o
);
  import tgad_pkg::*;

  // stage one: product
  logic        s1_valid_q;
  logic        s1_kind_q;
  logic [31:0] s1_pixel_q;
  logic [31:0] s1_prod_q;
  logic [15:0] s1_col_q;
  logic [2:0]  s1_code_q;
  logic        s1_last_q;

  // stage two: result word
  logic        s2_valid_q;
  logic        s2_kind_q;
  logic [31:0] s2_pixel_q;
  logic [31:0] s2_dest_q;
  logic [2:0]  s2_code_q;
  logic        s2_last_q;

  logic s2_load, s1_load;

  assign s2_load    = !s2_valid_q || out_o.ready;
  assign s1_load    = !s1_valid_q || s2_load;
  assign item_pop_o = item_valid_i && s1_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_load) s1_valid_q <= item_valid_i;
      if (s2_load) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      s1_kind_q  <= item_i.kind;
      s1_pixel_q <= item_i.pixel_word;
      s1_prod_q  <= 32'(item_i.dest_row) * 32'(item_i.width);
      s1_col_q   <= item_i.dest_col;
      s1_code_q  <= item_i.error_code;
      s1_last_q  <= item_i.last_pixel;
    end
    if (s2_load && s1_valid_q) begin
      s2_kind_q  <= s1_kind_q;
      s2_pixel_q <= (s1_kind_q == KIND_ERROR) ? 32'd0 : s1_pixel_q;
      s2_dest_q  <= (s1_kind_q == KIND_ERROR) ? 32'd0 : s1_prod_q + 32'(s1_col_q);
      s2_code_q  <= (s1_kind_q == KIND_ERROR) ? s1_code_q : 3'd0;
      s2_last_q  <= (s1_kind_q == KIND_ERROR) ? 1'b0 : s1_last_q;
    end
  end

  assign out_o.valid      = s2_valid_q;
  assign out_o.kind       = s2_kind_q;
  assign out_o.pixel_word = s2_pixel_q;
  assign out_o.dest_index = s2_dest_q;
  assign out_o.error_code = s2_code_q;
  assign out_o.last_pixel = s2_last_q;

`ifndef SYNTHESIS
  a_error_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && s2_kind_q == KIND_ERROR |->
      s2_dest_q == 32'd0 && s2_pixel_q == 32'd0 && !s2_last_q)
    else $error("error word carries pixel fields");

  a_pixel_code_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && s2_kind_q == KIND_PIXEL |-> s2_code_q == 3'd0)
    else $error("pixel word carries an error code");

  a_s1_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_load |=> s1_valid_q && $stable(s1_prod_q) && $stable(s1_pixel_q))
    else $error("stage one lost or changed while stalled");

  a_no_pop_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_o |-> s1_load)
    else $error("item taken while stage one blocked");
`endif

endmodule

[sv/tga_truecolor_stream_decoder.sv]
// targa 32-bit uncompressed stream decoder top level
// throughput: one byte word per cycle, limited only by the parser queue filling
// path: the byte that completes a result word passes through the queue write, the product
//   stage and the output register, in that order, before the word appears
// reset: rst_ni is asynchronous active low; the parser returns to idle and
//   ignores bytes until one marked start_of_file, queue and pipeline empty
module tga_truecolor_stream_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  tgad_in_if.sink    in_byte_i,
  tgad_out_if.source out_result_o
);
  import tgad_pkg::*;

  // parser to queue
  logic       byte_accept;
  logic       front_push;
  tgad_item_t front_item;
  logic       queue_full;

  // queue to address unit
  logic       queue_valid;
  tgad_item_t queue_item;
  logic       queue_pop;

  // a byte is taken whenever the queue has room, since any byte may yield a word
  assign in_byte_i.ready = !queue_full;
  assign byte_accept     = in_byte_i.valid && in_byte_i.ready;

  // front: header checks, id skip, pixel assembly and source-to-dest row/column
  tgad_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (byte_accept),
    .data_byte_i     (in_byte_i.data_byte),
    .start_of_file_i (in_byte_i.start_of_file),
    .push_o          (front_push),
    .push_item_o     (front_item)
  );

  // decouples byte intake from output stalls
  tgad_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_push),
    .push_item_i (front_item),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .item_o      (queue_item)
  );

  // back: dest index = row * width + column, then the output register
  tgad_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (queue_valid),
    .item_i       (queue_item),
    .item_pop_o   (queue_pop),
    .out_o        (out_result_o)
  );

endmodule

[sim/tgad_decode_checker.sv]
// checker for the targa stream decoder: predicts result words from accepted bytes and compares
`timescale 1ns / 1ps

module tgad_decode_checker (
  input  logic clk_i,
  input  logic rst_ni,
  tgad_in_if   byte_mon_i,
  tgad_out_if  result_mon_i,
  output int   fail_count_o,
  output int   pending_o
);
  import tgad_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEADER,
    ST_ID,
    ST_PIXEL,
    ST_DONE
  } parse_state_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] pixel_word;
    logic [31:0] dest_index;
    logic [2:0]  error_code;
    logic        last_pixel;
  } decoded_word_t;

  parse_state_e  st;
  logic [4:0]    hdr_pos;
  logic [7:0]    prev_byte;
  logic [7:0]    id_left;
  logic [15:0]   img_w;
  logic [15:0]   img_h;
  logic [7:0]    desc;
  logic [23:0]   pix_acc;
  logic [1:0]    byte_idx;
  logic [15:0]   src_col;
  logic [15:0]   src_row;
  logic [31:0]   row_base;

  decoded_word_t due_words[$];
  int            mismatch_count = 0;
  int            pending_count = 0;
  int            words_seen = 0;

  assign fail_count_o = mismatch_count;
  assign pending_o    = pending_count;

  function automatic void restart_parse();
    st        = ST_IDLE;
    hdr_pos   = '0;
    prev_byte = '0;
    id_left   = '0;
    img_w     = '0;
    img_h     = '0;
    desc      = '0;
    pix_acc   = '0;
    byte_idx  = '0;
    src_col   = '0;
    src_row   = '0;
    row_base  = '0;
  endfunction

  // first destination index of a source row
  function automatic logic [31:0] row_start(input logic [15:0] row);
    logic [15:0] drow;
    drow = desc[DESC_TOP_TO_BOTTOM] ? row : img_h - 16'd1 - row;
    return 32'(drow) * 32'(img_w);
  endfunction

  function automatic void start_pixels();
    st       = ST_PIXEL;
    byte_idx = '0;
    pix_acc  = '0;
    src_col  = '0;
    src_row  = '0;
    row_base = row_start(16'd0);
  endfunction

  function automatic void push_error(input tgad_err_e code);
    due_words.push_back('{kind: KIND_ERROR, pixel_word: '0, dest_index: '0,
                          error_code: code, last_pixel: 1'b0});
    st = ST_DONE;
  endfunction

  function automatic void take_header_byte(input logic [7:0] b);
    logic [4:0]  pos;
    logic [15:0] pair;
    pos       = hdr_pos;
    pair      = {b, prev_byte};
    hdr_pos   = pos + 5'd1;
    prev_byte = b;
    case (pos)
      HDR_ID_LEN:     id_left = b;
      HDR_CMAP_TYPE:  if (b != 8'd0) push_error(ERR_CMAP);
      HDR_IMG_TYPE:   if (b != TRUECOLOR_TYPE) push_error(ERR_TYPE);
      HDR_CMAP_FIRST,
      HDR_CMAP_LEN:   if (pair != 16'd0) push_error(ERR_CMAP);
      HDR_CMAP_ENTRY: if (b != 8'd0) push_error(ERR_CMAP);
      HDR_X_ORIGIN:   if (pair != 16'd0) push_error(ERR_XORG);
      HDR_Y_ORIGIN:   if (pair != 16'd0) push_error(ERR_YORG);
      HDR_WIDTH: begin
        img_w = pair;
        if (pair == 16'd0) push_error(ERR_WIDTH);
      end
      HDR_HEIGHT: begin
        img_h = pair;
        if (pair == 16'd0) push_error(ERR_HEIGHT);
      end
      HDR_DEPTH:      if (b != REQUIRED_DEPTH) push_error(ERR_DEPTH);
      HDR_DESCRIPTOR: begin
        desc = b;
        if (b[3:0] != REQUIRED_ALPHA) push_error(ERR_ALPHA);
        else if (id_left != 8'd0) st = ST_ID;
        else start_pixels();
      end
      default: ;
    endcase
  endfunction

  function automatic void take_pixel_byte(input logic [7:0] b);
    logic [15:0] col;
    logic        at_last_col;
    logic        at_last_row;
    if (byte_idx != LAST_PIXEL_BYTE) begin
      pix_acc  = pix_acc | (24'(b) << (8 * byte_idx));
      byte_idx = byte_idx + 2'd1;
    end else begin
      col         = desc[DESC_RIGHT_TO_LEFT] ? img_w - 16'd1 - src_col : src_col;
      at_last_col = (17'(src_col) + 17'd1) >= 17'(img_w);
      at_last_row = (17'(src_row) + 17'd1) >= 17'(img_h);
      due_words.push_back('{kind: KIND_PIXEL, pixel_word: {b, pix_acc},
                            dest_index: row_base + 32'(col), error_code: '0,
                            last_pixel: at_last_col && at_last_row});
      byte_idx = '0;
      pix_acc  = '0;
      if (at_last_col && at_last_row) begin
        st = ST_DONE;
      end else if (at_last_col) begin
        src_col  = '0;
        src_row  = src_row + 16'd1;
        row_base = row_start(src_row);
      end else begin
        src_col = src_col + 16'd1;
      end
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic sof);
    if (sof) begin
      restart_parse();
      st = ST_HEADER;
    end
    case (st)
      ST_HEADER: take_header_byte(b);
      ST_ID: begin
        id_left = id_left - 8'd1;
        if (id_left == 8'd0) start_pixels();
      end
      ST_PIXEL:  take_pixel_byte(b);
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: result word %0d: %s is %0h, expected %0h", $time, words_seen, what, got,
             want);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    decoded_word_t got;
    decoded_word_t want;
    if (!rst_ni) begin
      restart_parse();
      due_words.delete();
      pending_count = 0;
    end else begin
      // compare before predicting: a word can never come out at the edge of its own byte
      if (result_mon_i.valid && result_mon_i.ready) begin
        got = '{kind: result_mon_i.kind, pixel_word: result_mon_i.pixel_word,
                dest_index: result_mon_i.dest_index, error_code: result_mon_i.error_code,
                last_pixel: result_mon_i.last_pixel};
        if (due_words.size() == 0) begin
          report_mismatch("unexpected word, pixel", got.pixel_word, '0);
        end else begin
          want = due_words.pop_front();
          if (got.kind !== want.kind)
            report_mismatch("kind", 32'(got.kind), 32'(want.kind));
          if (got.pixel_word !== want.pixel_word)
            report_mismatch("pixel_word", got.pixel_word, want.pixel_word);
          if (got.dest_index !== want.dest_index)
            report_mismatch("dest_index", got.dest_index, want.dest_index);
          if (got.error_code !== want.error_code)
            report_mismatch("error_code", 32'(got.error_code), 32'(want.error_code));
          if (got.last_pixel !== want.last_pixel)
            report_mismatch("last_pixel", 32'(got.last_pixel), 32'(want.last_pixel));
        end
        words_seen++;
      end
      if (byte_mon_i.valid && byte_mon_i.ready)
        decode_byte(byte_mon_i.data_byte, byte_mon_i.start_of_file);
      pending_count = due_words.size();
    end
  end

endmodule

[sim/tb_tga_truecolor_stream_decoder.sv]
// testbench top for the targa stream decoder: byte stimulus, output stalls, watchdog and verdict
`timescale 1ns / 1ps

module tb_tga_truecolor_stream_decoder;
  import tgad_pkg::*;

  localparam int HEADER_BYTES  = 18;
  localparam int RANDOM_BYTES  = 650;  // consumed bytes in the random part
  localparam int STALL_LIMIT   = 1000; // cycles with no word moving on either side
  localparam int DRAIN_CYCLES  = 10;   // extra wait after the drain before the verdict
  localparam int FAULT_KINDS   = 11;

  // header defects, each one aimed at the byte that completes its field
  typedef enum int {
    FAULT_NONE,
    FAULT_CMAP_TYPE,
    FAULT_IMG_TYPE,
    FAULT_CMAP_FIRST,
    FAULT_CMAP_LEN,
    FAULT_CMAP_ENTRY,
    FAULT_X_ORIGIN,
    FAULT_Y_ORIGIN,
    FAULT_WIDTH,
    FAULT_HEIGHT,
    FAULT_DEPTH,
    FAULT_ALPHA
  } header_fault_e;

  logic clk_i;
  logic rst_ni;
  bit   steady_q;        // no idling on either side while set
  int   fed_bytes;
  int   idle_cycles = 0;
  int   mismatches;
  int   pending;

  tgad_in_if  byte_ch ();
  tgad_out_if result_ch ();

  tga_truecolor_stream_decoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_byte_i   (byte_ch),
    .out_result_o(result_ch)
  );

  tgad_decode_checker decode_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_mon_i  (byte_ch),
    .result_mon_i(result_ch),
    .fail_count_o(mismatches),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly no gap, some short, a few long
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_q || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one byte word; valid stays high after acceptance until the next falling edge
  task automatic send_byte(input logic [7:0] b, input logic sof);
    int gap;
    gap = idle_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_ch.valid         <= 1'b1;
    byte_ch.data_byte     <= b;
    byte_ch.start_of_file <= sof;
    do @(posedge clk_i); while (!byte_ch.ready);
  endtask

  // hold the sender until every predicted word has come out
  task automatic drain_results();
    @(negedge clk_i);
    byte_ch.valid <= 1'b0;
    wait (pending == 0);
  endtask

  // one file: header, optional defect, id bytes and pixel bytes, maybe cut short
  task automatic send_file(input int id_len, input int w, input int h, input logic [7:0] desc,
                           input header_fault_e fault, input bit cut_short);
    logic [7:0] hdr [HEADER_BYTES];
    int         cut;
    int         hdr_len;
    int         v;
    int         i;
    int         cap;
    longint     full_len;
    longint     body_len;
    longint     j;
    hdr = '{default: 8'h00};
    hdr[HDR_ID_LEN]     = 8'(id_len);
    hdr[HDR_IMG_TYPE]   = TRUECOLOR_TYPE;
    {hdr[HDR_WIDTH], hdr[HDR_WIDTH - 1]}   = 16'(w);
    {hdr[HDR_HEIGHT], hdr[HDR_HEIGHT - 1]} = 16'(h);
    hdr[HDR_DEPTH]      = REQUIRED_DEPTH;
    hdr[HDR_DESCRIPTOR] = desc;
    cut = HDR_DESCRIPTOR;
    case (fault)
      FAULT_CMAP_TYPE: begin
        hdr[HDR_CMAP_TYPE] = 8'($urandom_range(1, 255));
        cut = HDR_CMAP_TYPE;
      end
      FAULT_IMG_TYPE: begin
        // any type but true color
        v = $urandom_range(0, 254);
        if (v >= TRUECOLOR_TYPE) v++;
        hdr[HDR_IMG_TYPE] = 8'(v);
        cut = HDR_IMG_TYPE;
      end
      FAULT_CMAP_FIRST: begin
        {hdr[HDR_CMAP_FIRST], hdr[HDR_CMAP_FIRST - 1]} = 16'($urandom_range(1, 65535));
        cut = HDR_CMAP_FIRST;
      end
      FAULT_CMAP_LEN: begin
        {hdr[HDR_CMAP_LEN], hdr[HDR_CMAP_LEN - 1]} = 16'($urandom_range(1, 65535));
        cut = HDR_CMAP_LEN;
      end
      FAULT_CMAP_ENTRY: begin
        hdr[HDR_CMAP_ENTRY] = 8'($urandom_range(1, 255));
        cut = HDR_CMAP_ENTRY;
      end
      FAULT_X_ORIGIN: begin
        {hdr[HDR_X_ORIGIN], hdr[HDR_X_ORIGIN - 1]} = 16'($urandom_range(1, 65535));
        cut = HDR_X_ORIGIN;
      end
      FAULT_Y_ORIGIN: begin
        {hdr[HDR_Y_ORIGIN], hdr[HDR_Y_ORIGIN - 1]} = 16'($urandom_range(1, 65535));
        cut = HDR_Y_ORIGIN;
      end
      FAULT_WIDTH: begin
        {hdr[HDR_WIDTH], hdr[HDR_WIDTH - 1]} = 16'h0000;
        cut = HDR_WIDTH;
      end
      FAULT_HEIGHT: begin
        {hdr[HDR_HEIGHT], hdr[HDR_HEIGHT - 1]} = 16'h0000;
        cut = HDR_HEIGHT;
      end
      FAULT_DEPTH: begin
        v = $urandom_range(0, 254);
        if (v >= REQUIRED_DEPTH) v++;
        hdr[HDR_DEPTH] = 8'(v);
        cut = HDR_DEPTH;
      end
      FAULT_ALPHA: begin
        v = $urandom_range(0, 14);
        if (v >= REQUIRED_ALPHA) v++;
        hdr[HDR_DESCRIPTOR][3:0] = 4'(v);
        cut = HDR_DESCRIPTOR;
      end
      default: ;
    endcase

    // a bad header ends at the failing byte, the rest is ignored anyway
    hdr_len = (fault == FAULT_NONE) ? HEADER_BYTES : cut + 1;
    for (i = 0; i < hdr_len; i++) send_byte(hdr[i], i == 0);
    fed_bytes += hdr_len;
    if (fault != FAULT_NONE) begin
      // a few bytes after the error, all ignored
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
      return;
    end

    full_len = longint'(id_len) + 4 * longint'(w) * longint'(h);
    if (cut_short) begin
      // next start lands in the id, mid-pixel or mid-image
      cap = (full_len > 61) ? 60 : int'(full_len - 1);
      body_len = $urandom_range(0, cap);
    end else begin
      body_len = full_len;
    end
    for (j = 0; j < body_len; j++)
      send_byte(($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom), 1'b0);
    fed_bytes += int'(body_len);

    // bytes past the last pixel are ignored until the next start
    if (!cut_short && $urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
  endtask

  // result side: random stalls of mixed length, none in steady stretches
  initial begin : result_stalls
    int hold_left;
    int stall;
    hold_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (steady_q) begin
        result_ch.ready <= 1'b1;
        hold_left = 0;
      end else if (hold_left > 0) begin
        hold_left--;
      end else if (result_ch.ready) begin
        stall = idle_gap();
        if (stall > 0) begin
          result_ch.ready <= 1'b0;
          hold_left = stall - 1;
        end else begin
          hold_left = $urandom_range(0, 6);
        end
      end else begin
        result_ch.ready <= 1'b1;
        hold_left = $urandom_range(0, 6);
      end
    end
  end

  // watchdog: ends the run when no word moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles < STALL_LIMIT) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      $display("tb_tga_truecolor_stream_decoder failed");
      $finish;
    end
  end

  initial begin : stimulus
    int            w;
    int            h;
    int            id_len;
    int            pick;
    int            fault_turn;
    header_fault_e fault;
    logic [7:0]    desc;
    bit            big;

    rst_ni                <= 1'b0;
    byte_ch.valid         <= 1'b0;
    byte_ch.data_byte     <= 8'h00;
    byte_ch.start_of_file <= 1'b0;
    steady_q   = 1'b0;
    fed_bytes  = 0;
    fault_turn = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: byte before any start, abandoned start, smallest image, early error
    send_byte(8'hA5, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_file(0, 1, 1, 8'h38, FAULT_NONE, 1'b0);
    send_file(0, 1, 1, 8'h08, FAULT_CMAP_TYPE, 1'b0);
    drain_results();

    // random files, mostly well formed; header defects taken in turn
    fed_bytes = 0;
    while (fed_bytes < RANDOM_BYTES) begin
      steady_q = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      big  = 1'b0;
      if (pick < 70) begin
        w = $urandom_range(1, 3);
        h = $urandom_range(1, 3);
      end else if (pick < 88) begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 3);
      end else begin
        // extreme sizes, abandoned after a few pixels
        big = 1'b1;
        w = $urandom_range(0, 1) ? 65535 : $urandom_range(1, 65535);
        h = $urandom_range(0, 1) ? 65535 : $urandom_range(1, 65535);
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) id_len = 0;
      else if (pick < 96) id_len = $urandom_range(1, 6);
      else id_len = 255;
      desc = {4'($urandom_range(0, 15)), REQUIRED_ALPHA};
      if ($urandom_range(0, 99) < 45) begin
        fault = header_fault_e'(FAULT_CMAP_TYPE + fault_turn % FAULT_KINDS);
        fault_turn++;
      end else begin
        fault = FAULT_NONE;
      end
      send_file(id_len, w, h, desc, fault, big || ($urandom_range(0, 9) == 0));
      if ($urandom_range(0, 9) == 0) drain_results();
    end

    steady_q = 1'b0;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("tb_tga_truecolor_stream_decoder passed");
    else
      $display("tb_tga_truecolor_stream_decoder failed");
    $finish;
  end

endmodule

[filelist.f]
sv/tgad_pkg.sv
sv/tgad_if.sv
sv/tgad_front.sv
sv/tgad_queue.sv
sv/tgad_back.sv
sv/tga_truecolor_stream_decoder.sv
sim/tgad_decode_checker.sv
sim/tb_tga_truecolor_stream_decoder.sv
